FILE: hdl/fcfrb_pkg.sv
package fcfrb_pkg;

   localparam int NUM_REGS = 6;

   // register numbers
   localparam logic [2:0] REG_ACR    = 3'd0;
   localparam logic [2:0] REG_KEY    = 3'd1;
   localparam logic [2:0] REG_OPTKEY = 3'd2;
   localparam logic [2:0] REG_SR     = 3'd3;
   localparam logic [2:0] REG_CR     = 3'd4;
   localparam logic [2:0] REG_OPTCR  = 3'd5;

   // response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BOUNDS   = 2'd1;
   localparam logic [1:0] STATUS_RESERVED = 2'd2;
   localparam logic [1:0] STATUS_LOCKED   = 2'd3;

   localparam logic [31:0] KEY_FIRST  = 32'h4567_0123;
   localparam logic [31:0] KEY_SECOND = 32'hCDEF_89AB;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [31:0] CR_RESET   = 32'h8000_0000;
   localparam int          LOCK_BIT   = 31;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic commit;
   } fcfrb_cmd_type;

   // non-reserved start bits per register
   function automatic logic [31:0] valid_bits(input logic [2:0] r);
      logic [31:0] v;
      v = ALL_ONES;
      unique case (r)
         REG_ACR:   v = ~((32'hF << 4) | 32'hFFFF_E000);
         REG_SR:    v = ~((32'h3 << 2) | (32'h7F << 9) | (32'h7FFF << 17));
         REG_CR:    v = ~((32'h1 << 7) | (32'h3F << 10) | (32'h7F << 17) | (32'h1F << 26));
         REG_OPTCR: v = ~((32'h1 << 4) | (32'h7F << 24));
         default:   v = ALL_ONES;
      endcase
      return v;
   endfunction

   // field width in bits for a register and start bit
   function automatic logic [5:0] field_width(input logic [2:0] r, input logic [4:0] pos);
      logic [5:0] w;
      w = 6'd1;
      unique case (r)
         REG_ACR:              w = (pos == 5'd0) ? 6'd4 : 6'd1;
         REG_KEY, REG_OPTKEY:  w = 6'd32;
         REG_CR: begin
            if (pos == 5'd3) w = 6'd4;
            else if (pos == 5'd8) w = 6'd2;
            else w = 6'd1;
         end
         REG_OPTCR: begin
            if (pos == 5'd2) w = 6'd2;
            else if (pos == 5'd8 || pos == 5'd16) w = 6'd8;
            else w = 6'd1;
         end
         default:              w = 6'd1;
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/fcfrb_ctrl.sv
module fcfrb_ctrl
   import fcfrb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output fcfrb_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // result goes out once the output register is free
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/fcfrb_datapath.sv
module fcfrb_datapath
   import fcfrb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fcfrb_cmd_type cmd,
   input  logic          mode,
   input  logic [2:0]    reg_select,
   input  logic [5:0]    bit_pos,
   input  logic [31:0]   write_value,
   output logic [31:0]   read_data,
   output logic [1:0]    status
);

   logic        mode_ff;
   logic [2:0]  reg_ff;
   logic [5:0]  pos_ff;
   logic [31:0] val_ff;

   logic [31:0] bank_ff [NUM_REGS];
   logic [31:0] bank_in [NUM_REGS];
   logic        key_stage_ff, key_stage_in;
   logic [31:0] read_data_ff, read_data_in;
   logic [1:0]  status_ff, status_in;

   logic        reg_ok;
   logic [4:0]  pos5;
   logic [5:0]  width;
   logic        overrun;
   logic [31:0] mask;
   logic [31:0] cur;
   logic        is_key;
   logic [31:0] starts;

   assign pos5    = pos_ff[4:0];
   assign reg_ok  = (reg_ff < 3'(NUM_REGS)) && !pos_ff[5];
   assign width   = field_width(reg_ff, pos5);
   assign overrun = ({2'b00, pos5} + {1'b0, width}) > 7'd32;
   assign mask    = width[5] ? ALL_ONES : ((32'd1 << width) - 32'd1);
   assign cur     = reg_ok ? bank_ff[reg_ff] : '0;
   assign is_key  = (reg_ff == REG_KEY) || (reg_ff == REG_OPTKEY);
   assign starts  = valid_bits(reg_ff);

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) bank_in[i] = bank_ff[i];
      key_stage_in = key_stage_ff;
      read_data_in = '0;
      status_in    = STATUS_OK;
      if (!mode_ff) begin
         priority if (!reg_ok || overrun) begin
            read_data_in = ALL_ONES;
            status_in    = STATUS_BOUNDS;
         end else if (is_key) begin
            read_data_in = '0;
         end else begin
            read_data_in = (cur >> pos5) & mask;
         end
      end else begin
         priority if (!reg_ok) begin
            status_in = STATUS_BOUNDS;
         end else if (!starts[pos5]) begin
            status_in = STATUS_RESERVED;
         end else if (overrun) begin
            status_in = STATUS_BOUNDS;
         end else if (val_ff > mask) begin
            status_in = STATUS_RESERVED;
         end else if (reg_ff == REG_KEY) begin
            // two-word unlock sequence, any miss restarts it
            if (!key_stage_ff && val_ff == KEY_FIRST) begin
               key_stage_in = 1'b1;
            end else begin
               if (key_stage_ff && val_ff == KEY_SECOND) begin
                  bank_in[REG_CR][LOCK_BIT] = 1'b0;
               end
               key_stage_in = 1'b0;
            end
         end else if (reg_ff == REG_OPTKEY) begin
            status_in = STATUS_OK;
         end else if (reg_ff == REG_CR && bank_ff[REG_CR][LOCK_BIT]) begin
            status_in = STATUS_LOCKED;
         end else begin
            bank_in[reg_ff] = (cur & ~(mask << pos5)) | ((val_ff << pos5) & (mask << pos5));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= mode;
         reg_ff  <= reg_select;
         pos_ff  <= bit_pos;
         val_ff  <= write_value;
      end
      if (cmd.commit) begin
         read_data_ff <= read_data_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) bank_ff[i] <= '0;
         bank_ff[REG_CR] <= CR_RESET;
         key_stage_ff    <= 1'b0;
      end else if (cmd.commit) begin
         for (int i = 0; i < NUM_REGS; i++) bank_ff[i] <= bank_in[i];
         key_stage_ff <= key_stage_in;
      end
   end

   assign read_data = read_data_ff;
   assign status    = status_ff;

endmodule

FILE: hdl/flash_ctrl_field_register_bank_top.sv
// channel   | dir | tdata                                             | tuser
// request   | in  | [2:0] reg_select, [8:3] bit_pos, [40:9] write_value | [0] mode
// response  | out | [31:0] read_data                                  | [1:0] status
//
// each request takes two steps: capture, then field decode and read-modify-write
// on the register bank; the next request is taken only after the commit
// reset is synchronous, active high; it relocks the control register and
// restarts the key sequence
// the response sits in an output register; a new request is taken while it
// waits, and the next result is held back until the response is taken
module flash_ctrl_field_register_bank_top
   import fcfrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [2:0] reg_select, [8:3] bit_pos, [40:9] write_value
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_data
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   fcfrb_cmd_type cmd;

   // controller: request capture and response handshake
   fcfrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath: field decode, checks, register bank and unlock state
   fcfrb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .mode        (req_tuser[0]),
      .reg_select  (req_tdata[2:0]),
      .bit_pos     (req_tdata[8:3]),
      .write_value (req_tdata[40:9]),
      .read_data   (rsp_tdata),
      .status      (rsp_tuser)
   );

endmodule

FILE: hdl/fcfrb_checker.sv
module fcfrb_checker
   import fcfrb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a fresh response only rises for a request that was taken and then passed the execute state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without request");

   // lock and reserved rejections only come from writes, which return zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_LOCKED || rsp_tuser == STATUS_RESERVED)
      |-> rsp_tdata == '0)
      else $error("write rejection with nonzero data");

endmodule

bind flash_ctrl_field_register_bank_top fcfrb_checker u_fcfrb_checker (.*);

FILE: tb/sv/testbench.sv
module testbench;
   import fcfrb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // register numbers past the end of the bank
   localparam logic [2:0] REG_BAD_LO = 3'd6;
   localparam logic [2:0] REG_BAD_HI = 3'd7;

   localparam int RANDOM_REQUESTS = 950;
   localparam int DIRECTED_ROWS   = 26;
   localparam int TOTAL_REQUESTS  = RANDOM_REQUESTS + DIRECTED_ROWS;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_REPORTS     = 10;

   // one field access as the block sees it
   typedef struct packed {
      logic        mode;
      logic [2:0]  reg_sel;
      logic [5:0]  bit_pos;
      logic [31:0] value;
   } access_t;

   // one response
   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } reply_t;

   // directed row: the access and, where it is obvious, the response it must give
   typedef struct packed {
      logic        mode;
      logic [2:0]  reg_sel;
      logic [5:0]  bit_pos;
      logic [31:0] value;
      logic        fixed;
      logic [31:0] exp_data;
      logic [1:0]  exp_status;
   } dir_row_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // [2:0] reg_select, [8:3] bit_pos, [40:9] write_value
   logic [0:0]  req_tuser  = '0;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] read_data
   logic [1:0]  rsp_tuser;         // [1:0] status

   // shadow of the register bank and the key sequence
   logic [31:0] bank_model [NUM_REGS];
   logic        key_armed;

   reply_t  expected_replies [$];
   access_t planned_requests [$];

   int fail_count   = 0;
   int cycle_count  = 0;
   int issued       = 0;
   int snd_idle_pct = 24;
   int rcv_idle_pct = 51;

   // walked in order right after reset; the lock bit is still set at the top
   dir_row_t directed_rows [DIRECTED_ROWS] = '{
      // lock bit reads back as set after reset
      '{1'b0, REG_CR,     6'd31, 32'hFFFF_FFFF, 1'b1, 32'h1,    STATUS_OK},
      // registers past the bank and start bits past 31
      '{1'b0, REG_BAD_LO, 6'd0,  32'h0,         1'b1, ALL_ONES, STATUS_BOUNDS},
      '{1'b1, REG_BAD_HI, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0,    STATUS_BOUNDS},
      '{1'b0, REG_ACR,    6'd32, 32'h0,         1'b1, ALL_ONES, STATUS_BOUNDS},
      // a 32 bit key field starting above bit 0 runs past bit 31
      '{1'b0, REG_KEY,    6'd1,  32'h0,         1'b1, ALL_ONES, STATUS_BOUNDS},
      '{1'b1, REG_KEY,    6'd31, 32'h1,         1'b1, 32'h0,    STATUS_BOUNDS},
      // reserved start bits and a value too wide for its field
      '{1'b1, REG_ACR,    6'd4,  32'h0,         1'b1, 32'h0,    STATUS_RESERVED},
      '{1'b1, REG_SR,     6'd31, 32'h1,         1'b1, 32'h0,    STATUS_RESERVED},
      '{1'b1, REG_ACR,    6'd0,  32'h10,        1'b1, 32'h0,    STATUS_RESERVED},
      '{1'b1, REG_ACR,    6'd0,  32'hF,         1'b1, 32'h0,    STATUS_OK},
      '{1'b0, REG_ACR,    6'd0,  32'h0,         1'b0, 32'h0,    STATUS_OK},
      // control is locked; the reserved-bit check wins over the lock
      '{1'b1, REG_CR,     6'd0,  32'h1,         1'b1, 32'h0,    STATUS_LOCKED},
      '{1'b1, REG_CR,     6'd7,  32'h0,         1'b1, 32'h0,    STATUS_RESERVED},
      // key register is write only
      '{1'b0, REG_KEY,    6'd0,  32'h0,         1'b1, 32'h0,    STATUS_OK},
      // broken key sequence leaves the lock in place
      '{1'b1, REG_KEY,    6'd0,  KEY_FIRST,     1'b1, 32'h0,    STATUS_OK},
      '{1'b1, REG_KEY,    6'd0,  32'h0,         1'b1, 32'h0,    STATUS_OK},
      '{1'b1, REG_KEY,    6'd0,  KEY_SECOND,    1'b1, 32'h0,    STATUS_OK},
      '{1'b1, REG_CR,     6'd3,  32'h1,         1'b1, 32'h0,    STATUS_LOCKED},
      // proper unlock
      '{1'b1, REG_KEY,    6'd0,  KEY_FIRST,     1'b1, 32'h0,    STATUS_OK},
      '{1'b1, REG_KEY,    6'd0,  KEY_SECOND,    1'b1, 32'h0,    STATUS_OK},
      '{1'b1, REG_CR,     6'd3,  32'hF,         1'b1, 32'h0,    STATUS_OK},
      '{1'b0, REG_CR,     6'd3,  32'h0,         1'b0, 32'h0,    STATUS_OK},
      // option key swallows anything
      '{1'b1, REG_OPTKEY, 6'd0,  32'hFFFF_FFFF, 1'b1, 32'h0,    STATUS_OK},
      '{1'b1, REG_OPTCR,  6'd16, 32'hFF,        1'b1, 32'h0,    STATUS_OK},
      // relock through bit 31, then control writes bounce again
      '{1'b1, REG_CR,     6'd31, 32'h1,         1'b1, 32'h0,    STATUS_OK},
      '{1'b1, REG_CR,     6'd0,  32'h1,         1'b1, 32'h0,    STATUS_LOCKED}
   };

   flash_ctrl_field_register_bank_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // start bits that may begin a written field
   function automatic logic [31:0] legal_starts(input logic [2:0] r);
      case (r)
         REG_ACR:   return ~((32'hF << 4) | 32'hFFFF_E000);
         REG_SR:    return ~((32'h3 << 2) | (32'h7F << 9) | (32'h7FFF << 17));
         REG_CR:    return ~((32'h1 << 7) | (32'h3F << 10) | (32'h7F << 17) | (32'h1F << 26));
         REG_OPTCR: return ~((32'h1 << 4) | (32'h7F << 24));
         default:   return ALL_ONES;
      endcase
   endfunction

   // width of the field that starts at a given bit
   function automatic int field_bits(input logic [2:0] r, input int pos);
      case (r)
         REG_ACR:            return (pos == 0) ? 4 : 1;
         REG_KEY, REG_OPTKEY: return 32;
         REG_CR:             return (pos == 3) ? 4 : (pos == 8) ? 2 : 1;
         REG_OPTCR:          return (pos == 2) ? 2 : (pos == 8 || pos == 16) ? 8 : 1;
         default:            return 1;
      endcase
   endfunction

   function automatic logic [31:0] field_mask(input int w);
      return (w >= 32) ? ALL_ONES : ((32'h1 << w) - 32'h1);
   endfunction

   // applies one access to the shadow bank and returns the response it earns
   function automatic reply_t apply_access(input access_t a);
      reply_t      rep;
      int          pos;
      int          w;
      logic [31:0] m;
      logic [31:0] starts;
      rep = '{read_data: 32'h0, status: STATUS_OK};
      pos = int'(a.bit_pos);
      if (int'(a.reg_sel) >= NUM_REGS || pos > 31) begin
         rep.read_data = a.mode ? 32'h0 : ALL_ONES;
         rep.status    = STATUS_BOUNDS;
         return rep;
      end
      w      = field_bits(a.reg_sel, pos);
      m      = field_mask(w);
      starts = legal_starts(a.reg_sel);
      if (!a.mode) begin
         if (pos + w > 32) begin
            rep.read_data = ALL_ONES;
            rep.status    = STATUS_BOUNDS;
         end else if (a.reg_sel == REG_KEY || a.reg_sel == REG_OPTKEY) begin
            rep.read_data = 32'h0;
         end else begin
            rep.read_data = (bank_model[a.reg_sel] >> pos) & m;
         end
         return rep;
      end
      if (!starts[pos]) begin
         rep.status = STATUS_RESERVED;
      end else if (pos + w > 32) begin
         rep.status = STATUS_BOUNDS;
      end else if (a.value > m) begin
         rep.status = STATUS_RESERVED;
      end else if (a.reg_sel == REG_KEY) begin
         // first key arms, second key right after it unlocks, anything else disarms
         if (!key_armed && a.value == KEY_FIRST) begin
            key_armed = 1'b1;
         end else begin
            if (key_armed && a.value == KEY_SECOND) bank_model[REG_CR][LOCK_BIT] = 1'b0;
            key_armed = 1'b0;
         end
      end else if (a.reg_sel == REG_OPTKEY) begin
         rep.status = STATUS_OK;
      end else if (a.reg_sel == REG_CR && bank_model[REG_CR][LOCK_BIT]) begin
         rep.status = STATUS_LOCKED;
      end else begin
         m = m << pos;
         bank_model[a.reg_sel] = (bank_model[a.reg_sel] & ~m) | ((a.value << pos) & m);
      end
      return rep;
   endfunction

   // queues the next burst of random traffic, mostly well formed
   function automatic void plan_traffic();
      access_t     a;
      int          pick;
      int          pos;
      logic [31:0] m;
      logic [31:0] starts;
      pick = $urandom_range(0, 99);
      a    = '0;
      if (pick < 14) begin
         // unlock sequence, one in five with a bad second key
         a.mode    = 1'b1;
         a.reg_sel = REG_KEY;
         a.value   = KEY_FIRST;
         planned_requests.push_back(a);
         a.value = ($urandom_range(0, 4) == 0) ? $urandom : KEY_SECOND;
         planned_requests.push_back(a);
      end else if (pick < 18) begin
         // relock
         a.mode    = 1'b1;
         a.reg_sel = REG_CR;
         a.bit_pos = 6'd31;
         a.value   = 32'h1;
         planned_requests.push_back(a);
      end else if (pick < 58) begin
         // legal field write, biased toward the wide fields
         a.mode    = 1'b1;
         a.reg_sel = 3'($urandom_range(0, NUM_REGS - 1));
         pos       = $urandom_range(0, 31);
         if ($urandom_range(0, 1) == 1) begin
            case (a.reg_sel)
               REG_ACR:   pos = 0;
               REG_CR:    pos = ($urandom_range(0, 1) == 1) ? 3 : 8;
               REG_OPTCR: pos = ($urandom_range(0, 2) == 0) ? 2 : ($urandom_range(0, 1) ? 8 : 16);
               default:   pos = 0;
            endcase
         end
         starts = legal_starts(a.reg_sel);
         while (!starts[pos] || pos + field_bits(a.reg_sel, pos) > 32)
            pos = $urandom_range(0, 31);
         a.bit_pos = 6'(pos);
         m         = field_mask(field_bits(a.reg_sel, pos));
         a.value   = ($urandom_range(0, 3) == 0) ? m : ($urandom & m);
         planned_requests.push_back(a);
      end else if (pick < 84) begin
         // field read of a real register, garbage in the value field
         a.reg_sel = 3'($urandom_range(0, NUM_REGS - 1));
         a.bit_pos = 6'($urandom_range(0, 31));
         a.value   = $urandom;
         planned_requests.push_back(a);
      end else begin
         // raw noise over every field
         a.mode    = 1'($urandom_range(0, 1));
         a.reg_sel = 3'($urandom_range(0, 7));
         a.bit_pos = 6'($urandom_range(0, 63));
         a.value   = $urandom;
         planned_requests.push_back(a);
      end
   endfunction

   // drives one request, waits for it to be taken and logs what it must return
   task automatic send_request(input access_t a, input logic fixed, input reply_t fixed_reply);
      int     gap;
      reply_t predicted;
      gap = ($urandom_range(0, 99) < snd_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, a.value, a.bit_pos, a.reg_sel};
      req_tuser  <= a.mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // state moves even when the response is typed in the table
      predicted = apply_access(a);
      expected_replies.push_back(fixed ? fixed_reply : predicted);
      issued++;
      // idling phases: receiver-heavy, then sender-heavy, then none
      if (issued * 3 >= TOTAL_REQUESTS * 2) begin
         snd_idle_pct = 0;
         rcv_idle_pct = 0;
      end else if (issued * 3 >= TOTAL_REQUESTS) begin
         snd_idle_pct = 51;
         rcv_idle_pct = 24;
      end
   endtask

   // response side: random back-pressure and in-order compare
   always @(posedge clock) begin
      reply_t want;
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected response: read_data %h status %0d", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_tdata !== want.read_data || rsp_tuser !== want.status) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: read_data exp %h got %h, status exp %0d got %0d",
                           want.read_data, rsp_tdata, want.status, rsp_tuser);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      access_t a;
      reply_t  r;
      for (int i = 0; i < NUM_REGS; i++) bank_model[i] = 32'h0;
      bank_model[REG_CR] = CR_RESET;
      key_armed          = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         a = '{mode: directed_rows[i].mode, reg_sel: directed_rows[i].reg_sel,
               bit_pos: directed_rows[i].bit_pos, value: directed_rows[i].value};
         r = '{read_data: directed_rows[i].exp_data, status: directed_rows[i].exp_status};
         send_request(a, directed_rows[i].fixed, r);
      end

      // random traffic
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (planned_requests.size() == 0) plan_traffic();
         a = planned_requests.pop_front();
         send_request(a, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      // drain the response side
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/fcfrb_pkg.sv
hdl/fcfrb_ctrl.sv
hdl/fcfrb_datapath.sv
hdl/flash_ctrl_field_register_bank_top.sv
hdl/fcfrb_checker.sv
tb/sv/testbench.sv
